// ----- rtl/sha256_stream_hash_assert.svh -----
`ifndef SHA256_STREAM_HASH_ASSERT_SVH
`define SHA256_STREAM_HASH_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define SHA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define SHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sha256_pkg.sv -----
package sha256_pkg;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] FILL_LAST  = 6'd63;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [2:0] WORD_LAST  = 3'd7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       take_byte;
    logic       pad;
    logic       write_len;
    logic       start;
    logic       round;
    logic       finish;
    logic       restart;
    logic [5:0] rnd;
    logic [2:0] word_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
  } dp_stat_t;

  function automatic logic [31:0] init_hash(input logic [2:0] idx);
    logic [31:0] r;
    case (idx)
      3'd0:    r = 32'h6a09e667;
      3'd1:    r = 32'hbb67ae85;
      3'd2:    r = 32'h3c6ef372;
      3'd3:    r = 32'ha54ff53a;
      3'd4:    r = 32'h510e527f;
      3'd5:    r = 32'h9b05688c;
      3'd6:    r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] r;
    case (idx)
      6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
      6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
      6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
      6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
      6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7;  default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

// ----- rtl/sha256_ctrl.sv -----
module sha256_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_byte_valid,
  input  logic                 in_last,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           word_index,
  output logic                 digest_last,
  input  sha256_pkg::dp_stat_t stat,
  output sha256_pkg::dp_cmd_t  cmd
);
  import sha256_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PAD   = 6'b000010,
    S_LEN   = 6'b000100,
    S_ROUND = 6'b001000,
    S_FINAL = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t     state_r, state_nxt;
  state_t     after_r, after_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic [2:0] idx_r, idx_nxt;

  always_comb begin
    state_nxt    = state_r;
    after_nxt    = after_r;
    rnd_nxt      = rnd_r;
    idx_nxt      = idx_r;
    cmd          = '0;
    cmd.rnd      = rnd_r;
    cmd.word_sel = idx_r;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_byte_valid) begin
            cmd.take_byte = 1'b1;
            if (stat.fill == FILL_LAST) begin
              // This byte completes the block; padding waits until it is compressed.
              cmd.start = 1'b1;
              rnd_nxt   = '0;
              state_nxt = S_ROUND;
              after_nxt = in_last ? S_PAD : S_IDLE;
            end else if (in_last) begin
              state_nxt = S_PAD;
            end
          end else if (in_last) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.pad   = 1'b1;
        cmd.start = 1'b1;
        rnd_nxt   = '0;
        state_nxt = S_ROUND;
        if (stat.fill >= LEN_POS) begin
          // No room for the length field: it goes into an extra block.
          after_nxt = S_LEN;
        end else begin
          cmd.write_len = 1'b1;
          after_nxt     = S_OUT;
        end
      end
      S_LEN: begin
        cmd.write_len = 1'b1;
        cmd.start     = 1'b1;
        rnd_nxt       = '0;
        state_nxt     = S_ROUND;
        after_nxt     = S_OUT;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        rnd_nxt   = rnd_r + 6'd1;
        if (rnd_r == ROUND_LAST) begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd.finish = 1'b1;
        idx_nxt    = '0;
        state_nxt  = after_r;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == WORD_LAST) begin
            cmd.restart = 1'b1;
            state_nxt   = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign word_index  = idx_r;
  assign digest_last = (idx_r == WORD_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      after_r <= S_IDLE;
      rnd_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      after_r <= after_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// ----- rtl/sha256_dp.sv -----
module sha256_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sha256_pkg::dp_cmd_t  cmd,
  input  logic [7:0]           data_byte,
  output sha256_pkg::dp_stat_t stat,
  output logic [31:0]          digest_word
);
  import sha256_pkg::*;

  logic [31:0] h_r [8];
  logic [31:0] h_nxt [8];
  logic [31:0] v_r [8];
  logic [31:0] v_nxt [8];
  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];
  logic [5:0]  fill_r, fill_nxt;
  logic [60:0] count_r, count_nxt;
  logic [63:0] bit_len;
  logic [7:0]  ins_byte;
  logic [3:0]  ins_word;
  logic [31:0] t1, t2, w_new;

  assign bit_len  = {count_r, 3'b000};
  assign ins_byte = cmd.take_byte ? data_byte : PAD_BYTE;
  assign ins_word = fill_r[5:2];

  assign t1 = v_r[7] + big_sig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
            + round_k(cmd.rnd) + w_r[0];
  assign t2 = big_sig0(v_r[0])
            + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  // The buffer acts as a sliding schedule window: w_r[0] is the word of this round.
  assign w_new = w_r[0] + small_sig0(w_r[1]) + w_r[9] + small_sig1(w_r[14]);

  always_comb begin
    w_nxt     = w_r;
    fill_nxt  = fill_r;
    count_nxt = count_r;
    if (cmd.take_byte || cmd.pad) begin
      case (fill_r[1:0])
        2'd0:    w_nxt[ins_word][31:24] = ins_byte;
        2'd1:    w_nxt[ins_word][23:16] = ins_byte;
        2'd2:    w_nxt[ins_word][15:8]  = ins_byte;
        default: w_nxt[ins_word][7:0]   = ins_byte;
      endcase
    end
    if (cmd.take_byte) begin
      fill_nxt  = fill_r + 6'd1;
      count_nxt = count_r + 61'd1;
    end
    if (cmd.write_len) begin
      w_nxt[14] = bit_len[63:32];
      w_nxt[15] = bit_len[31:0];
    end
    if (cmd.round) begin
      for (int i = 0; i < 15; i++) begin
        w_nxt[i] = w_r[i + 1];
      end
      w_nxt[15] = w_new;
    end
    if (cmd.finish) begin
      for (int i = 0; i < 16; i++) begin
        w_nxt[i] = '0;
      end
    end
    if (cmd.restart) begin
      fill_nxt  = '0;
      count_nxt = '0;
    end
  end

  always_comb begin
    v_nxt = v_r;
    h_nxt = h_r;
    if (cmd.start) begin
      v_nxt = h_r;
    end else if (cmd.round) begin
      v_nxt[7] = v_r[6];
      v_nxt[6] = v_r[5];
      v_nxt[5] = v_r[4];
      v_nxt[4] = v_r[3] + t1;
      v_nxt[3] = v_r[2];
      v_nxt[2] = v_r[1];
      v_nxt[1] = v_r[0];
      v_nxt[0] = t1 + t2;
    end
    if (cmd.finish) begin
      for (int i = 0; i < 8; i++) begin
        h_nxt[i] = h_r[i] + v_r[i];
      end
    end else if (cmd.restart) begin
      for (int i = 0; i < 8; i++) begin
        h_nxt[i] = init_hash(3'(i));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= init_hash(3'(i));
      end
      for (int i = 0; i < 16; i++) begin
        w_r[i] <= '0;
      end
      fill_r  <= '0;
      count_r <= '0;
    end else begin
      h_r     <= h_nxt;
      w_r     <= w_nxt;
      fill_r  <= fill_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
  end

  assign stat.fill   = fill_r;
  assign digest_word = h_r[cmd.word_sel];

endmodule

// ----- rtl/sha256_stream_hash.sv -----
// Message bytes: one transaction per cycle while a block is filling; the 64th byte
// of a block starts its compression (the rounds of the single round unit, then one
// chaining add), during which no bytes are taken. After the last transaction the
// padded block is compressed, after the full block if that byte filled one and
// before a length block if needed; then eight results, one per cycle with out_ready.
// Synchronous active-low reset loads the initial hash and empties the block buffer.
module sha256_stream_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_digest_last
);
  import sha256_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sha256_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_byte_valid (in_byte_valid),
    .in_last       (in_last),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .word_index    (out_word_index),
    .digest_last   (out_digest_last),
    .stat          (stat),
    .cmd           (cmd)
  );

  sha256_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .data_byte   (in_data_byte),
    .stat        (stat),
    .digest_word (out_digest_word)
  );

endmodule

// ----- rtl/sha256_stream_hash_chk.sv -----
`include "sha256_stream_hash_assert.svh"

module sha256_stream_hash_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_digest_last
);

  // A stalled result transaction keeps its word and position.
  `SHA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_digest_word) && $stable(out_word_index), "stalled digest word changed")

  // Input is never taken while digest words are pending.
  `SHA_ASSERT_NOW(a_no_overlap, in_ready, !out_valid, "input ready during digest output")

  `SHA_ASSERT_NOW(a_last_flag, out_valid, out_digest_last == (out_word_index == 3'd7), "digest_last does not match word index")

  // Digest words follow one another without gaps.
  `SHA_ASSERT_NEXT(a_word_seq, out_valid && out_ready && !out_digest_last, out_valid && (out_word_index == $past(out_word_index) + 3'd1), "digest word sequence broken")

  // After the final word the engine is ready for a new message.
  `SHA_ASSERT_NEXT(a_restart, out_valid && out_ready && out_digest_last, in_ready && !out_valid, "engine not ready after digest")

endmodule

bind sha256_stream_hash sha256_stream_hash_chk u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_digest_word (out_digest_word),
  .out_word_index  (out_word_index),
  .out_digest_last (out_digest_last)
);
